// ===== rtl/hec_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hec_pkg: shared constants and helpers for the Hamming encoder / corrector
// Widths, command and register codes, and the fixed code-position maps.
// ----------------------------------------------------------------------------
package hec_pkg;

   // Field widths
   localparam int MAX_DATA_BITS = 57;
   localparam int CODE_BITS     = 63;
   localparam int SYN_BITS      = 6;
   localparam int PAR_MAX       = 6;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 6;

   // Commands
   localparam logic CMD_ENCODE = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_DATA_LEN   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ODD_PARITY = 2'd1;

   // Reset values
   localparam logic [CSR_DATA_BITS-1:0] DATA_LEN_RESET = 6'd4;

   typedef logic [CODE_BITS-1:0]     code_type;
   typedef logic [MAX_DATA_BITS-1:0] data_type;
   typedef logic [SYN_BITS-1:0]      syn_type;

   // Data bits go, in order, into the positions that are not powers of two
   function automatic code_type scatter_data(input data_type data);
      code_type word;
      int       j;
      word = '0;
      j    = 0;
      for (int i = 1; i <= CODE_BITS; i++) begin
         if ((i & (i - 1)) != 0) begin
            if (j < MAX_DATA_BITS) begin
               word[i-1] = data[j];
            end
            j++;
         end
      end
      return word;
   endfunction

   // Positions covered by parity bit 2^k: every position with bit k set
   function automatic code_type group_mask(input int k);
      code_type m;
      m = '0;
      for (int i = 1; i <= CODE_BITS; i++) begin
         m[i-1] = ((i >> k) & 1) != 0;
      end
      return m;
   endfunction

   // Smallest p with 2^p >= m + p + 1
   function automatic logic [2:0] parity_count(input logic [CSR_DATA_BITS-1:0] m);
      logic [2:0] p;
      logic       done;
      p    = 3'd0;
      done = 1'b0;
      for (int k = 0; k <= PAR_MAX; k++) begin
         if (!done) begin
            if ((7'd1 << k) >= (7'(m) + 7'(k) + 7'd1)) begin
               p    = 3'(k);
               done = 1'b1;
            end
         end
      end
      return p;
   endfunction

endpackage

// ===== rtl/hamming_encode_and_correct.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hamming_encode_and_correct: single-error-correcting Hamming codec
// Encodes a data word or checks and corrects a received code word.
// ----------------------------------------------------------------------------
// Usage:
//  - Command channel: pulse start with req_cmd and the payload; the transfer
//    is taken when start is high and busy is low. busy is only high during
//    reset, so a new command can be issued every cycle.
//  - req_cmd = encode uses req_data_word; decode uses req_received_code.
//  - Result channel: rsp_valid is high for exactly one cycle with the result
//    fields. The receiver cannot stall the block; results must be taken.
//  - Path: input register, then one pass of parity trees into the result
//    register, which drives rsp_valid. Throughput is one item per cycle
//    outside reset; the 63-bit XOR trees of the syndrome set the clock.
//  - CSR port: csr_we with csr_index / csr_wdata. Index 0 sets the data
//    length (0 acts as 1, above 57 as 57), index 1 selects odd parity. Other
//    indexes are ignored. Write only while no command is in flight.
//  - Reset (synchronous) drops any transfer in flight and restores a data
//    length of 4 with even parity.
// ----------------------------------------------------------------------------
module hamming_encode_and_correct (
   input  logic                                   clock,
   input  logic                                   reset,
   // command channel
   input  logic                                   start,
   output logic                                   busy,
   input  logic                                   req_cmd,
   input  logic [hec_pkg::MAX_DATA_BITS-1:0]      req_data_word,
   input  logic [hec_pkg::CODE_BITS-1:0]          req_received_code,
   // result channel
   output logic                                   rsp_valid,
   output logic [hec_pkg::CODE_BITS-1:0]          rsp_code_word,
   output logic [hec_pkg::SYN_BITS-1:0]           rsp_error_position,
   output logic                                   rsp_error_found,
   output logic                                   rsp_uncorrectable,
   // configuration port
   input  logic                                   csr_we,
   input  logic [hec_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [hec_pkg::CSR_DATA_BITS-1:0]      csr_wdata
);
   import hec_pkg::*;

   // Configuration registers
   logic [CSR_DATA_BITS-1:0] data_len_ff;
   logic                     odd_ff;

   // Derived code geometry, refreshed every cycle
   logic [CSR_DATA_BITS-1:0] m_in;
   logic [2:0]               p_in;
   logic [SYN_BITS-1:0]      r_in, r_ff;
   code_type                 mask_in, mask_ff;
   logic [PAR_MAX-1:0]       par_en_in, par_en_ff;

   // Input stage
   logic                     s1_valid_ff;
   logic                     s1_cmd_ff;
   data_type                 s1_data_ff;
   code_type                 s1_code_ff;
   logic                     accept;

   // Result stage
   logic                     rsp_valid_ff;
   code_type                 rsp_code_ff, rsp_code_in;
   syn_type                  rsp_pos_ff, rsp_pos_in;
   logic                     rsp_found_ff, rsp_found_in;
   logic                     rsp_bad_ff, rsp_bad_in;

   // Datapath intermediates
   code_type                 enc_word;
   code_type                 dec_word;
   syn_type                  syn;
   logic                     syn_bad;

   assign busy   = reset;
   assign accept = start && !busy;

   // CSR writes
   always_ff @(posedge clock) begin
      if (reset) begin
         data_len_ff <= DATA_LEN_RESET;
         odd_ff      <= 1'b0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_DATA_LEN:   data_len_ff <= csr_wdata;
            CSR_ODD_PARITY: odd_ff      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Clamp data length, then parity count, code length and enables
   always_comb begin
      if (data_len_ff == '0) begin
         m_in = 6'd1;
      end else if (data_len_ff > 6'(MAX_DATA_BITS)) begin
         m_in = 6'(MAX_DATA_BITS);
      end else begin
         m_in = data_len_ff;
      end
      p_in    = parity_count(m_in);
      r_in    = m_in + SYN_BITS'(p_in);
      mask_in = ~({CODE_BITS{1'b1}} << r_in);
      for (int k = 0; k < PAR_MAX; k++) begin
         par_en_in[k] = 3'(k) < p_in;
      end
   end

   always_ff @(posedge clock) begin
      r_ff      <= r_in;
      mask_ff   <= mask_in;
      par_en_ff <= par_en_in;
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      if (accept) begin
         s1_cmd_ff  <= req_cmd;
         s1_data_ff <= req_data_word;
         s1_code_ff <= req_received_code;
      end
   end

   // Encode: scatter data, then fill each active parity position
   always_comb begin
      code_type base;
      base     = scatter_data(s1_data_ff) & mask_ff;
      enc_word = base;
      for (int k = 0; k < PAR_MAX; k++) begin
         if (par_en_ff[k]) begin
            enc_word[(1 << k) - 1] = (^(base & group_mask(k))) ^ odd_ff;
         end
      end
   end

   // Decode: syndrome, range check and single-bit flip
   always_comb begin
      code_type rx;
      rx = s1_code_ff & mask_ff;
      for (int k = 0; k < PAR_MAX; k++) begin
         syn[k] = par_en_ff[k] & ((^(rx & group_mask(k))) ^ odd_ff);
      end
      syn_bad = syn > r_ff;
      if (syn != '0 && !syn_bad) begin
         dec_word = rx ^ (code_type'(1) << (syn - 6'd1));
      end else begin
         dec_word = rx;
      end
   end

   // Result select
   always_comb begin
      if (s1_cmd_ff == CMD_ENCODE) begin
         rsp_code_in  = enc_word;
         rsp_pos_in   = '0;
         rsp_found_in = 1'b0;
         rsp_bad_in   = 1'b0;
      end else begin
         rsp_code_in  = dec_word;
         rsp_pos_in   = syn;
         rsp_found_in = syn != '0;
         rsp_bad_in   = syn_bad;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (s1_valid_ff) begin
         rsp_code_ff  <= rsp_code_in;
         rsp_pos_ff   <= rsp_pos_in;
         rsp_found_ff <= rsp_found_in;
         rsp_bad_ff   <= rsp_bad_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_code_word      = rsp_code_ff;
   assign rsp_error_position = rsp_pos_ff;
   assign rsp_error_found    = rsp_found_ff;
   assign rsp_uncorrectable  = rsp_bad_ff;

   // Checks
   a_accept_to_stage: assert property (@(posedge clock) disable iff (reset)
      accept |=> s1_valid_ff)
      else $error("accepted transfer did not reach the input stage");

   a_stage_to_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff |=> rsp_valid_ff)
      else $error("input stage did not produce a result");

   a_rsp_has_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(s1_valid_ff))
      else $error("result strobe without a transfer");

   a_bad_implies_found: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_found_ff && rsp_pos_ff != '0))
      else $error("uncorrectable flag without a nonzero syndrome");

endmodule
